### rtl/core/cbba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbba_pkg;

	// Map geometry
	localparam int NUM_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int LIM_W      = $clog2(NUM_BLOCKS + 1);

	// Fixed field widths
	localparam int REG_W      = 11;
	localparam int ADDR_W     = 10;
	localparam int CNT_W      = 11;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 16;

	// Width of the shared index counter and its bound
	localparam int SCAN_W     = (LIM_W > REG_W) ? LIM_W : REG_W;

	localparam logic [REG_W-1:0] BLOCKS_RESET = REG_W'(1024);

	// Request kinds carried on s_tuser
	localparam logic REQ_FIND    = 1'b0;
	localparam logic REQ_RESERVE = 1'b1;

	// Result status carried on m_tuser
	localparam logic STAT_OK       = 1'b0;
	localparam logic STAT_NOTFOUND = 1'b1;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic             data;
	} map_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} map_rd_t;

endpackage

`default_nettype wire

### rtl/core/cbba_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Used/free map storage: one write port, one registered read port.
module cbba_map (
	input  wire logic              clk,
	input  wire cbba_pkg::map_wr_t wr,
	input  wire cbba_pkg::map_rd_t rd,
	output logic                   rdata
);

	logic mem [cbba_pkg::NUM_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/contiguous_block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit contiguous block allocator over a used/free bitmap of NUM_BLOCKS
// entries held in a single-port-write, registered-read memory. One index
// counter with one bound compare is reused by every operation, under a small
// sequencer that handles one transaction at a time. After reset the block runs
// a clearing pass that writes every map entry free, one per cycle, over all
// NUM_BLOCKS (1024) entries; s_tready stays low until it ends, while cfg writes
// are taken as usual. A find (s_tuser = 0) walks the map from block 0 one entry
// per cycle and stops at the first run of block_count free blocks, or answers
// not-found when nothing fits within min(blocks_in_use, NUM_BLOCKS) blocks; a
// zero count answers not-found at once. A reserve (s_tuser = 1) writes one map
// entry per cycle over the range clipped to the covered blocks and always
// answers status 0, address 0. One result stays in the output register until
// taken; the block returns to s_tready once it has handed its result to that
// register.
module contiguous_block_bitmap_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	// Configuration: blocks_in_use
	input  wire logic                              cfg_we,
	input  wire logic [cbba_pkg::REG_W-1:0]        cfg_wdata,

	// Requests
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [cbba_pkg::S_TDATA_W-1:0]    s_tdata,   // [9:0] start_index, [20:10] block_count, [23:21] zero
	input  wire logic                              s_tuser,   // req_type

	// Results
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [cbba_pkg::M_TDATA_W-1:0]         m_tdata,   // [9:0] address, [15:10] zero
	output logic                                   m_tuser    // status
);

	localparam int SCAN_W = cbba_pkg::SCAN_W;
	localparam int IDX_W  = cbba_pkg::IDX_W;
	localparam int ADDR_W = cbba_pkg::ADDR_W;
	localparam int CNT_W  = cbba_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_RESV,
		ST_WAIT
	} state_t;

	state_t                         state_q;
	logic [cbba_pkg::REG_W-1:0]     blocks_in_use_q;

	// Shared index counter and its bound
	logic [SCAN_W-1:0]              idx_q;
	logic [SCAN_W-1:0]              bound_q;
	logic                           in_range;

	// Find bookkeeping
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               run_q;
	logic [CNT_W-1:0]               run_next;
	logic [SCAN_W-1:0]              first_q;
	logic                           rd_vld_s1;
	logic [SCAN_W-1:0]              rd_idx_s1;

	// Pending result, then output register
	logic                           res_status_q;
	logic [ADDR_W-1:0]              res_addr_q;
	logic                           m_tvalid_q;
	logic                           m_status_q;
	logic [ADDR_W-1:0]              m_addr_q;

	// Request fields
	logic                           req_type;
	logic [ADDR_W-1:0]              start_index;
	logic [CNT_W-1:0]               block_count;

	logic [SCAN_W-1:0]              limit;
	logic [SCAN_W-1:0]              reg_ext;
	logic [SCAN_W:0]                resv_sum;
	logic [SCAN_W-1:0]              resv_end;

	cbba_pkg::map_wr_t              map_wr;
	cbba_pkg::map_rd_t              map_rd;
	logic                           map_rdata;

	logic                           s_fire;
	logic                           out_free;

	assign req_type    = s_tuser;
	assign start_index = s_tdata[ADDR_W-1:0];
	assign block_count = s_tdata[ADDR_W+CNT_W-1:ADDR_W];

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {(cbba_pkg::M_TDATA_W - ADDR_W)'(0), m_addr_q};

	// Covered size saturates at the map depth
	assign reg_ext = SCAN_W'(blocks_in_use_q);
	assign limit   = (reg_ext > SCAN_W'(cbba_pkg::NUM_BLOCKS)) ?
	                 SCAN_W'(cbba_pkg::NUM_BLOCKS) : reg_ext;

	// Reserve range end, clipped to the covered blocks; the sum keeps its carry
	assign resv_sum = (SCAN_W+1)'(start_index) + (SCAN_W+1)'(block_count);
	assign resv_end = (resv_sum > {1'b0, limit}) ? limit : resv_sum[SCAN_W-1:0];

	// The one compare that every walk shares
	assign in_range = (idx_q < bound_q);

	assign run_next = run_q + CNT_W'(1);

	always_comb begin
		map_wr.en   = 1'b0;
		map_wr.addr = idx_q[IDX_W-1:0];
		map_wr.data = 1'b0;
		map_rd.en   = 1'b0;
		map_rd.addr = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				map_wr.en   = in_range;
				map_wr.data = 1'b0;
			end
			ST_RESV: begin
				map_wr.en   = in_range;
				map_wr.data = 1'b1;
			end
			ST_FIND: begin
				map_rd.en   = in_range;
			end
			default: begin
			end
		endcase
	end

	cbba_map u_map (
		.clk   (clk),
		.wr    (map_wr),
		.rd    (map_rd),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			blocks_in_use_q <= cbba_pkg::BLOCKS_RESET;
			idx_q           <= '0;
			bound_q         <= SCAN_W'(cbba_pkg::NUM_BLOCKS);
			rd_vld_s1       <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				blocks_in_use_q <= cfg_wdata;
			end

			// Load a waiting result into a free output register; drop it once taken
			if ((state_q == ST_WAIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// Entry data comes back in the cycle after each read of the walk
			rd_vld_s1 <= (state_q == ST_FIND) && in_range;

			unique case (state_q)
				ST_CLEAR: begin
					// Sweep every entry free, then open the request side
					if (in_range) begin
						idx_q <= idx_q + SCAN_W'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (s_fire) begin
						if (req_type == cbba_pkg::REQ_RESERVE) begin
							idx_q   <= SCAN_W'(start_index);
							bound_q <= resv_end;
							state_q <= ST_RESV;
						end else begin
							idx_q   <= '0;
							bound_q <= limit;
							count_q <= block_count;
							run_q   <= '0;
							if (block_count == '0) begin
								res_status_q <= cbba_pkg::STAT_NOTFOUND;
								res_addr_q   <= '0;
								state_q      <= ST_WAIT;
							end else begin
								state_q <= ST_FIND;
							end
						end
					end
				end

				ST_FIND: begin
					// Issue the next read while the previous entry comes back
					rd_idx_s1 <= idx_q;
					if (in_range) begin
						idx_q <= idx_q + SCAN_W'(1);
					end
					if (rd_vld_s1) begin
						if (!map_rdata) begin
							if (run_q == '0) begin
								first_q <= rd_idx_s1;
							end
							run_q <= run_next;
							if (run_next == count_q) begin
								res_status_q <= cbba_pkg::STAT_OK;
								res_addr_q   <= (run_q == '0) ? rd_idx_s1[ADDR_W-1:0]
								                              : first_q[ADDR_W-1:0];
								state_q      <= ST_WAIT;
							end
						end else begin
							run_q <= '0;
						end
					end else if (!in_range) begin
						// Walk ended with no read in flight: nothing fits
						res_status_q <= cbba_pkg::STAT_NOTFOUND;
						res_addr_q   <= '0;
						state_q      <= ST_WAIT;
					end
				end

				ST_RESV: begin
					// Mark one entry used per cycle up to the clipped end
					if (in_range) begin
						idx_q <= idx_q + SCAN_W'(1);
					end else begin
						res_status_q <= cbba_pkg::STAT_OK;
						res_addr_q   <= '0;
						state_q      <= ST_WAIT;
					end
				end

				ST_WAIT: begin
					// Hold the result until the output register is free
					if (out_free) begin
						m_status_q <= res_status_q;
						m_addr_q   <= res_addr_q;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// One transaction at a time: an accepted request closes the request side
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

	// Returned map data always belongs to a read issued the cycle before
	a_read_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(map_rd.en))
		else $error("map data consumed without a matching read");

	// The map changes only during the clearing pass or a reserve walk
	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		map_wr.en |-> (state_q == ST_CLEAR || state_q == ST_RESV))
		else $error("map written outside clear or reserve");

	// A result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) && m_tvalid_q && !m_tready |=> $stable(m_addr_q))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
